// File: hdl/twss_pkg.sv
// ----------------------------------------------------------------------------
// twss_pkg
// Shared types and constants of the time-window sample statistics core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twss_pkg;

  // request commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // register map (word index)
  localparam int unsigned REG_WINDOW_MS  = 0;
  localparam int unsigned PADDR_W        = 3;
  localparam logic [15:0] WINDOW_MS_INIT = 16'd1000;

  // unit conversions
  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;

  // value limits, Q15.8
  localparam logic signed [23:0] VALUE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VALUE_MIN = 24'sh800000;

  // 48-bit saturation limits and the integral term cap (2^47)
  localparam logic signed [47:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT_NEG = 48'sh8000_0000_0000;
  localparam logic [47:0]        TERM_CAP = 48'h8000_0000_0000;
  // error * dt at or above this gives a capped term (1000 * 2^47)
  localparam logic [63:0] CAP_PRODUCT = 64'd140737488355328000;

  // shared divider dividend width
  localparam int unsigned DIV_W = 48;

  // one stored sample
  typedef struct packed {
    logic [63:0]        time_us;
    logic signed [23:0] value;
    logic signed [23:0] target;
    logic               ok;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/time_window_sample_statistics_core.sv
// Sliding time-window statistics over a ring of time-stamped samples kept in
// one synchronous memory of DEPTH entries. A push request evicts entries
// older than the window, appends the sample (dropping the oldest entry when
// the ring is full), then walks the ring one entry per cycle through a
// pipelined error-integral datapath, and finishes with at most two 48-step
// radix-2 divisions on one shared divider (mean and derivative). Requests are
// taken one at a time; a finished result waits in the output register while
// the next request is accepted. The ring needs no clearing after reset: only
// entries inside the fill count are read.
// ----------------------------------------------------------------------------
// time_window_sample_statistics_core
// Windowed count, mean, min, max, error integral and derivative of samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module time_window_sample_statistics_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                        clk,
  input  wire                        rst,
  // apb configuration
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [twss_pkg::PADDR_W-1:0] paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // requests
  input  wire                        req_valid,
  output logic                       req_ready,
  input  wire                        command,
  input  wire [63:0]                 time_us,
  input  wire signed [23:0]          sample_value,
  input  wire signed [23:0]          setpoint_value,
  input  wire [7:0]                  fault_code,
  // results
  output logic                       res_valid,
  input  wire                        res_ready,
  output logic [6:0]                 valid_count,
  output logic signed [23:0]         mean_value,
  output logic signed [23:0]         min_value,
  output logic signed [23:0]         max_value,
  output logic signed [47:0]         integral_sum,
  output logic signed [47:0]         error_derivative,
  output logic                       dropped_full
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SLW = CW + 1;
  localparam int unsigned SW  = 24 + CW;
  localparam int unsigned DCW = $clog2(twss_pkg::DIV_W);

  typedef enum logic [3:0] {
    S_IDLE, S_EV_RD, S_EV_CHK, S_APPEND, S_WALK_INIT, S_WALK, S_DRAIN,
    S_MEAN_LD, S_MEAN_RUN, S_MEAN_END, S_DERIV_LD, S_DERIV_RUN, S_DERIV_END,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [15:0] window_ms;
  logic [25:0] limit_us;

  assign pready   = 1'b1;
  assign limit_us = 26'(window_ms) * 26'(twss_pkg::US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= twss_pkg::WINDOW_MS_INIT;
    end else if (psel && penable && pwrite &&
                 paddr == twss_pkg::PADDR_W'(4 * twss_pkg::REG_WINDOW_MS)) begin
      window_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr == twss_pkg::PADDR_W'(4 * twss_pkg::REG_WINDOW_MS)) begin
      prdata = {16'd0, window_ms};
    end else begin
      prdata = 32'd0;
    end
  end

  // latched request
  logic               rq_cmd;
  logic [63:0]        rq_time;
  logic signed [23:0] rq_value;
  logic signed [23:0] rq_target;
  logic               rq_ok;
  logic               rq_drop;

  // ring control
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic [CW-1:0] walk_k;
  logic [AW-1:0] walk_idx;

  // sample memory
  twss_pkg::entry_t mem [DEPTH];
  twss_pkg::entry_t rd_q;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  twss_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // ring index arithmetic
  logic [AW-1:0]  head_inc;
  logic [AW-1:0]  idx_inc;
  logic           ring_full;
  logic [AW-1:0]  app_head;
  logic [CW-1:0]  app_fill;
  logic [SLW-1:0] slot_sum;
  logic [AW-1:0]  app_slot;
  logic [SLW-1:0] newest_sum;
  logic [AW-1:0]  newest_idx;
  logic [63:0]    age_us;

  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign idx_inc   = (walk_idx == AW'(DEPTH - 1)) ? '0 : walk_idx + 1'b1;
  assign ring_full = (fill == CW'(DEPTH));
  assign app_head  = ring_full ? head_inc : head;
  assign app_fill  = ring_full ? CW'(DEPTH - 1) : fill;
  assign slot_sum  = SLW'(app_head) + SLW'(app_fill);
  assign app_slot  = (slot_sum >= SLW'(DEPTH)) ? AW'(slot_sum - SLW'(DEPTH))
                                               : AW'(slot_sum);
  assign newest_sum = SLW'(head) + SLW'(fill) - SLW'(1);
  assign newest_idx = (newest_sum >= SLW'(DEPTH)) ? AW'(newest_sum - SLW'(DEPTH))
                                                  : AW'(newest_sum);
  assign age_us     = rq_time - rd_q.time_us;

  // memory port selection
  always_comb begin
    mem_re = ((state == S_EV_RD) && (fill != '0)) ||
             ((state == S_WALK) && (walk_k != fill));
    mem_ra = (state == S_EV_RD) ? head : walk_idx;
    mem_we = (state == S_APPEND);
    mem_wa = app_slot;
    mem_wd = '{time_us: rq_time, value: rq_value, target: rq_target, ok: rq_ok};
  end

  // walk statistics, fed by memory read data
  logic                p0_v;
  logic [CW-1:0]       st_cnt;
  logic signed [SW-1:0] st_sum;
  logic signed [23:0]  st_min;
  logic signed [23:0]  st_max;
  logic                have_prev;
  logic signed [24:0]  prev_err;
  logic [63:0]         prev_time;
  logic                has2;
  logic signed [25:0]  last_de;
  logic [63:0]         last_dt;
  logic signed [24:0]  cur_err;
  logic [63:0]         cur_dt;

  assign cur_err = 25'(rd_q.target) - 25'(rd_q.value);
  assign cur_dt  = rd_q.time_us - prev_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else begin
      p0_v <= (state == S_WALK) && (walk_k != fill);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK_INIT) begin
      st_cnt    <= '0;
      st_sum    <= '0;
      st_min    <= twss_pkg::VALUE_MAX;
      st_max    <= twss_pkg::VALUE_MIN;
      have_prev <= 1'b0;
      has2      <= 1'b0;
    end else if (p0_v && rd_q.ok) begin
      st_cnt <= st_cnt + 1'b1;
      st_sum <= st_sum + SW'(rd_q.value);
      if (rd_q.value < st_min) begin
        st_min <= rd_q.value;
      end
      if (rd_q.value > st_max) begin
        st_max <= rd_q.value;
      end
      if (have_prev) begin
        has2    <= 1'b1;
        last_de <= 26'(cur_err) - 26'(prev_err);
        last_dt <= cur_dt;
      end
      prev_err  <= cur_err;
      prev_time <= rd_q.time_us;
      have_prev <= 1'b1;
    end
  end

  // integral stage 1: magnitude and step
  logic        s1_v;
  logic        s1_neg;
  logic [23:0] s1_m;
  logic [63:0] s1_dt;
  logic [24:0] err_abs;

  assign err_abs = cur_err[24] ? 25'(-cur_err) : 25'(cur_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= p0_v && rd_q.ok && have_prev;
    end
    s1_neg <= cur_err[24];
    s1_m   <= err_abs[23:0];
    s1_dt  <= cur_dt;
  end

  // integral stage 2: partial products, huge steps cap a nonzero error
  logic        s2_v;
  logic        s2_neg;
  logic        s2_big;
  logic [55:0] s2_plo;
  logic [48:0] s2_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_neg <= s1_neg;
    s2_big <= (|s1_dt[63:57]) && (|s1_m);
    s2_plo <= 56'(s1_m) * 56'(s1_dt[31:0]);
    s2_phi <= 49'(s1_m) * 49'(s1_dt[56:32]);
  end

  // integral stage 3: full product and cap test
  logic [80:0] prod;

  assign prod = {s2_phi, 32'd0} + 81'(s2_plo);

  // divide by 1000, eight quotient bits per stage
  logic        dv_v   [9];
  logic        dv_neg [9];
  logic        dv_cap [9];
  logic [9:0]  dv_rem [9];
  logic [63:0] dv_dq  [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= s2_v;
    end
    dv_neg[0] <= s2_neg;
    dv_cap[0] <= s2_big || (prod >= 81'(twss_pkg::CAP_PRODUCT));
    dv_rem[0] <= '0;
    dv_dq[0]  <= {7'd0, prod[56:0]};
  end

  for (genvar j = 0; j < 8; j++) begin : g_div1000
    logic [9:0]  r_c;
    logic [63:0] q_c;
    logic [10:0] t_c;

    always_comb begin
      r_c = dv_rem[j];
      q_c = dv_dq[j];
      t_c = '0;
      for (int b = 0; b < 8; b++) begin
        t_c = {r_c, q_c[63]};
        if (t_c >= 11'(twss_pkg::US_PER_MS)) begin
          r_c = 10'(t_c - 11'(twss_pkg::US_PER_MS));
          q_c = {q_c[62:0], 1'b1};
        end else begin
          r_c = t_c[9:0];
          q_c = {q_c[62:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
      dv_neg[j+1] <= dv_neg[j];
      dv_cap[j+1] <= dv_cap[j];
      dv_rem[j+1] <= r_c;
      dv_dq[j+1]  <= q_c;
    end
  end

  // saturating accumulation of the integral
  logic [47:0]        term_mag;
  logic signed [49:0] term;
  logic signed [49:0] acc_sum;
  logic signed [47:0] integ;

  assign term_mag = dv_cap[8] ? twss_pkg::TERM_CAP : dv_dq[8][47:0];
  assign term     = dv_neg[8] ? -$signed(50'(term_mag)) : $signed(50'(term_mag));
  assign acc_sum  = 50'(integ) + term;

  always_ff @(posedge clk) begin
    if (state == S_WALK_INIT) begin
      integ <= '0;
    end else if (dv_v[8]) begin
      if (acc_sum > 50'(twss_pkg::SAT_POS)) begin
        integ <= twss_pkg::SAT_POS;
      end else if (acc_sum < 50'(twss_pkg::SAT_NEG)) begin
        integ <= twss_pkg::SAT_NEG;
      end else begin
        integ <= 48'(acc_sum);
      end
    end
  end

  logic busy;
  always_comb begin
    busy = p0_v || s1_v || s2_v;
    for (int i = 0; i < 9; i++) begin
      busy = busy || dv_v[i];
    end
  end

  // shared radix-2 divider
  logic [63:0]             div_rem;
  logic [twss_pkg::DIV_W-1:0] div_q;
  logic [63:0]             div_den;
  logic [DCW-1:0]          div_cnt;
  logic [64:0]             div_try;
  logic                    div_ge;

  assign div_try = {div_rem, div_q[twss_pkg::DIV_W-1]};
  assign div_ge  = (div_try >= {1'b0, div_den});

  // operand preparation
  logic [SW-1:0] sum_abs;
  logic [25:0]   de_abs;
  logic [45:0]   de_scaled;

  assign sum_abs   = st_sum[SW-1] ? SW'(-st_sum) : SW'(st_sum);
  assign de_abs    = last_de[25] ? 26'(-last_de) : 26'(last_de);
  assign de_scaled = 46'(de_abs) * 46'(twss_pkg::US_PER_S);

  logic signed [23:0] mean_r;
  logic signed [47:0] deriv_r;
  logic [23:0]        mean_mag;
  logic [47:0]        deriv_mag;

  assign mean_mag  = div_q[23:0];
  assign deriv_mag = div_q[47:0];
  assign req_ready = (state == S_IDLE);

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            rq_cmd    <= command;
            rq_time   <= time_us;
            rq_value  <= sample_value;
            rq_target <= setpoint_value;
            rq_ok     <= (fault_code == 8'd0);
            rq_drop   <= 1'b0;
            if (command == twss_pkg::CMD_CLEAR) begin
              if (fill > CW'(1)) begin
                head <= newest_idx;
                fill <= CW'(1);
              end
              state <= S_WALK_INIT;
            end else begin
              state <= S_EV_RD;
            end
          end
        end
        S_EV_RD: begin
          state <= (fill == '0) ? S_APPEND : S_EV_CHK;
        end
        S_EV_CHK: begin
          if (age_us > 64'(limit_us)) begin
            head  <= head_inc;
            fill  <= fill - 1'b1;
            state <= S_EV_RD;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          head    <= app_head;
          fill    <= app_fill + 1'b1;
          rq_drop <= ring_full;
          state   <= S_WALK_INIT;
        end
        S_WALK_INIT: begin
          walk_k   <= '0;
          walk_idx <= head;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_k == fill) begin
            state <= S_DRAIN;
          end else begin
            walk_k   <= walk_k + 1'b1;
            walk_idx <= idx_inc;
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state <= S_MEAN_LD;
          end
        end
        S_MEAN_LD: begin
          div_rem <= '0;
          div_q   <= twss_pkg::DIV_W'(sum_abs);
          div_den <= 64'(st_cnt);
          div_cnt <= '0;
          if (st_cnt == '0) begin
            mean_r <= '0;
            state  <= S_DERIV_LD;
          end else begin
            state <= S_MEAN_RUN;
          end
        end
        S_MEAN_RUN, S_DERIV_RUN: begin
          div_rem <= div_ge ? 64'(div_try - {1'b0, div_den}) : div_try[63:0];
          div_q   <= {div_q[twss_pkg::DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(twss_pkg::DIV_W - 1)) begin
            state <= (state == S_MEAN_RUN) ? S_MEAN_END : S_DERIV_END;
          end
        end
        S_MEAN_END: begin
          mean_r <= st_sum[SW-1] ? -$signed(mean_mag) : $signed(mean_mag);
          state  <= S_DERIV_LD;
        end
        S_DERIV_LD: begin
          div_rem <= '0;
          div_q   <= twss_pkg::DIV_W'(de_scaled);
          div_den <= last_dt;
          div_cnt <= '0;
          if (!has2 || last_dt == '0) begin
            deriv_r <= '0;
            state   <= S_FINISH;
          end else begin
            state <= S_DERIV_RUN;
          end
        end
        S_DERIV_END: begin
          deriv_r <= last_de[25] ? -$signed(deriv_mag) : $signed(deriv_mag);
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            valid_count      <= 7'(st_cnt);
            mean_value       <= mean_r;
            min_value        <= st_min;
            max_value        <= st_max;
            integral_sum     <= integ;
            error_derivative <= deriv_r;
            dropped_full     <= rq_drop;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  // the integral pipeline is empty whenever a request can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !busy)
    else $error("walk pipeline busy while idle");

  // a clear leaves at most the newest entry
  a_clear_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_INIT && rq_cmd == twss_pkg::CMD_CLEAR) |-> fill <= CW'(1))
    else $error("clear left more than one entry");

  // a dropped entry is only reported with a full ring after the append
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_INIT && rq_drop) |-> fill == CW'(DEPTH))
    else $error("drop flagged without a full ring");

  // the walk never runs past the fill count
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_k <= fill)
    else $error("walk past fill count");

endmodule

`default_nettype wire
